// ===== rtl/core/lwbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lwbsc_pkg
// Shared constants, codes and controller/datapath interface types for the
// fully associative lru write-back sector cache unit.
// ----------------------------------------------------------------------------
package lwbsc_pkg;

   localparam int NUM_SLOTS    = 64;
   localparam int IDX_W        = $clog2(NUM_SLOTS);
   localparam int SLOT_W       = 6;
   localparam int SECTOR_W     = 32;
   localparam int STAMP_W      = 64;
   localparam int PERIOD_W     = 10;
   localparam int OP_W         = 2;
   localparam int MAX_RESULTS  = 64;
   localparam int CNT_W        = $clog2(MAX_RESULTS);
   localparam int RSP_FIELD_W  = SLOT_W + 3 + SECTOR_W;
   localparam int RSP_DATA_W   = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELD_W;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);

   localparam logic [OP_W-1:0] OP_READ     = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE    = 2'd1;
   localparam logic [OP_W-1:0] OP_PREFETCH = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef struct packed {
      logic load;       // take the request item, clear scan state
      logic scan;       // read slot idx and step the scan
      logic idx_inc;    // advance slot index
      logic acc_emit;   // emit access answer and update the slot
      logic fl_emit;    // emit flush writeback for slot idx
   } cmd_type;

   typedef struct packed {
      logic req_is_tick;
      logic tick_flush;
      logic idx_last;
      logic fl_sel;
      logic fl_final;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/lwbsc_ram.sv =====
// ----------------------------------------------------------------------------
// lwbsc_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module lwbsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/lwbsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwbsc_ctrl
// Sequencer: accepts an item, walks the slots for lookup or flush and
// hands results to the output register.
// ----------------------------------------------------------------------------
module lwbsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output lwbsc_pkg::cmd_type     cmd,
   input  lwbsc_pkg::status_type  status
);
   import lwbsc_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_DRAIN    = 3'd2;
   localparam logic [2:0] S_ACC_OUT  = 3'd3;
   localparam logic [2:0] S_FL_CHECK = 3'd4;
   localparam logic [2:0] S_FL_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (!status.req_is_tick) begin
                  state_in = S_SCAN;
               end else if (status.tick_flush) begin
                  state_in = S_FL_CHECK;
               end
            end
         end
         S_SCAN: begin
            cmd.scan    = 1'b1;
            cmd.idx_inc = 1'b1;
            if (status.idx_last) begin
               state_in = S_DRAIN;
            end
         end
         // last read data is evaluated here
         S_DRAIN: begin
            state_in = S_ACC_OUT;
         end
         S_ACC_OUT: begin
            if (status.out_free) begin
               cmd.acc_emit = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FL_CHECK: begin
            if (status.fl_sel) begin
               state_in = S_FL_OUT;
            end else if (status.idx_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_FL_OUT: begin
            if (status.out_free) begin
               cmd.fl_emit = 1'b1;
               if (status.fl_final) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_FL_CHECK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/lwbsc_datapath.sv =====
// ----------------------------------------------------------------------------
// lwbsc_datapath
// Slot state, tag and stamp rams, lookup and lru scan registers, tick timer
// and the registered result stage.
// ----------------------------------------------------------------------------
module lwbsc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [lwbsc_pkg::SECTOR_W-1:0]        req_tdata,
   input  logic [lwbsc_pkg::OP_W-1:0]            req_tuser,
   input  logic                                  csr_wr_en,
   input  logic [lwbsc_pkg::PERIOD_W-1:0]        csr_wr_data,
   input  lwbsc_pkg::cmd_type                    cmd,
   output lwbsc_pkg::status_type                 status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lwbsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import lwbsc_pkg::*;

   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [STAMP_W-1:0]    tick_time_ff, tick_time_in;
   logic [PERIOD_W-1:0]   countdown_ff, countdown_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [SECTOR_W-1:0]   sector_ff, sector_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]  dirty_ff, dirty_in;
   logic [NUM_SLOTS-1:0]  stamp_ok_ff, stamp_ok_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic                  free_ff, free_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]      min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0]    min_stamp_ff, min_stamp_in;
   logic [SECTOR_W-1:0]   min_tag_ff, min_tag_in;
   logic [CNT_W-1:0]      fl_cnt_ff, fl_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [SECTOR_W-1:0]   tag_q;
   logic [STAMP_W-1:0]    stamp_q;
   logic [STAMP_W-1:0]    rd_stamp;
   logic                  rd_valid;
   logic [IDX_W-1:0]      acc_slot;
   logic                  acc_wb;
   logic [SECTOR_W-1:0]   acc_wb_sector;
   logic                  tag_we;
   logic                  stamp_we;
   logic                  out_free;
   logic                  more_dirty;
   logic                  fl_final;
   logic [NUM_SLOTS-1:0]  fl_mask;

   lwbsc_ram #(.WIDTH(SECTOR_W), .DEPTH(NUM_SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (acc_slot),
      .wr_data (sector_ff),
      .rd_addr (idx_ff),
      .rd_data (tag_q)
   );

   lwbsc_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_SLOTS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (acc_slot),
      .wr_data (tick_time_ff),
      .rd_addr (idx_ff),
      .rd_data (stamp_q)
   );

   // a stamp entry never written reads as zero
   assign rd_stamp = stamp_ok_ff[rd_idx_ff] ? stamp_q : '0;
   assign rd_valid = valid_ff[rd_idx_ff];

   assign acc_slot      = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : min_idx_ff);
   assign acc_wb        = !hit_ff && !free_ff && dirty_ff[min_idx_ff];
   assign acc_wb_sector = acc_wb ? min_tag_ff : '0;
   assign tag_we        = cmd.acc_emit && !hit_ff;
   assign stamp_we      = cmd.acc_emit && (op_ff != OP_PREFETCH);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fl_mask  = valid_ff & dirty_ff;

   always_comb begin
      more_dirty = 1'b0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
         if ((j > int'(idx_ff)) && fl_mask[j]) begin
            more_dirty = 1'b1;
         end
      end
   end

   assign fl_final = !more_dirty || (fl_cnt_ff == CNT_W'(MAX_RESULTS - 1));

   assign status.req_is_tick = (req_tuser == OP_TICK);
   assign status.tick_flush  = (countdown_ff <= PERIOD_W'(1));
   assign status.idx_last    = (idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign status.fl_sel      = fl_mask[idx_ff];
   assign status.fl_final    = fl_final;
   assign status.out_free    = out_free;

   always_comb begin
      period_in    = period_ff;
      tick_time_in = tick_time_ff;
      countdown_in = countdown_ff;
      op_in        = op_ff;
      sector_in    = sector_ff;
      idx_in       = idx_ff;
      rd_vld_in    = cmd.scan;
      rd_idx_in    = idx_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      stamp_ok_in  = stamp_ok_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      min_idx_in   = min_idx_ff;
      min_stamp_in = min_stamp_ff;
      min_tag_in   = min_tag_ff;
      fl_cnt_in    = fl_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         period_in = csr_wr_data;
      end

      if (cmd.load) begin
         op_in     = req_tuser;
         sector_in = req_tdata;
         idx_in    = '0;
         hit_in    = 1'b0;
         free_in   = 1'b0;
         fl_cnt_in = '0;
         if (req_tuser == OP_TICK) begin
            tick_time_in = tick_time_ff + STAMP_W'(1);
            if (countdown_ff <= PERIOD_W'(1)) begin
               countdown_in = period_ff;
            end else begin
               countdown_in = countdown_ff - PERIOD_W'(1);
            end
         end
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // evaluate the slot read in the previous cycle
      if (rd_vld_ff) begin
         if (!hit_ff && rd_valid && (tag_q == sector_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
         end
         if (!free_ff && !rd_valid) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         // strict compare keeps the lowest index on ties
         if ((rd_idx_ff == '0) || (rd_stamp < min_stamp_ff)) begin
            min_idx_in   = rd_idx_ff;
            min_stamp_in = rd_stamp;
            min_tag_in   = tag_q;
         end
      end

      if (cmd.acc_emit) begin
         if (!hit_ff) begin
            valid_in[acc_slot] = 1'b1;
            dirty_in[acc_slot] = 1'b0;
         end
         if (op_ff != OP_PREFETCH) begin
            stamp_ok_in[acc_slot] = 1'b1;
         end
         if (op_ff == OP_WRITE) begin
            dirty_in[acc_slot] = 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_ACCESS;
         rsp_last_in  = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, acc_wb_sector, acc_wb, !hit_ff, hit_ff,
                         SLOT_W'(acc_slot)};
      end

      if (cmd.fl_emit) begin
         dirty_in[idx_ff] = 1'b0;
         fl_cnt_in        = fl_cnt_ff + CNT_W'(1);
         rsp_valid_in     = 1'b1;
         rsp_kind_in      = KIND_FLUSH;
         rsp_last_in      = fl_final;
         rsp_data_in      = {{RSP_PAD_W{1'b0}}, tag_q, 1'b1, 1'b0, 1'b0, SLOT_W'(idx_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         tick_time_ff <= '0;
         countdown_ff <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         stamp_ok_ff  <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         fl_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         tick_time_ff <= tick_time_in;
         countdown_ff <= countdown_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         stamp_ok_ff  <= stamp_ok_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         fl_cnt_ff    <= fl_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sector_ff    <= sector_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_tag_ff   <= min_tag_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/lru_write_back_sector_cache_unit.sv =====
// Access (read, write, prefetch): the tag and stamp rams are walked one slot per
//   cycle, the last read data is evaluated, and the result is loaded into the
//   output register once it is free. Tick without flush: done at accept.
// Tick with flush: slots are walked one per cycle up to the last dirty slot (all
//   64 if none is dirty), halting while a writeback waits for the output register.
// One item at a time; the next item is accepted once the last result is handed
//   to the output register. Synchronous active-high reset, no clearing pass.
// ----------------------------------------------------------------------------
// lru_write_back_sector_cache_unit
// Tag and lru policy controller for a fully associative write-back sector
// cache with periodic flush of dirty slots.
// ----------------------------------------------------------------------------
module lru_write_back_sector_cache_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lwbsc_pkg::SECTOR_W-1:0]        req_tdata,  // sector
   input  logic [lwbsc_pkg::OP_W-1:0]            req_tuser,  // op
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // slot[5:0], hit[6], fill_needed[7], writeback_needed[8],
   // writeback_sector[40:9], zero fill above
   output logic [lwbsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tuser,  // kind
   output logic                                  rsp_tlast,  // last
   input  logic                                  csr_wr_en,
   input  logic [lwbsc_pkg::PERIOD_W-1:0]        csr_wr_data // flush_period
);
   import lwbsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   lwbsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lwbsc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTHESIS
   // one item at a time; a tick may leave the input open
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != OP_TICK)) |=> !req_tready)
      else $error("input taken while an item is in work");

   // a hit never asks for fill or writeback
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_ACCESS) && rsp_tdata[6]) |->
      (!rsp_tdata[7] && !rsp_tdata[8]))
      else $error("hit with fill or writeback");

   // access answers are single, flush items always write back
   a_kind_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_ACCESS) ? rsp_tlast :
                      (rsp_tdata[8] && !rsp_tdata[6] && !rsp_tdata[7])))
      else $error("bad result shape");

   // no result is produced while the block is idle and ready
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_tready && !rsp_tvalid) |=> (!rsp_tvalid || !$past(req_tready) ||
                                       $past(req_tvalid)))
      else $error("result appeared without an item");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lru write-back sector cache unit. A short
// directed table covers reset state, field extremes, every op, first-tick
// flush and free-slot fill; random traffic over a sector pool drives the
// cache into eviction, dirty writeback and multi-slot flushes under several
// flush periods and idle patterns. Every result item is checked against an
// in-bench tag/lru predictor.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lwbsc_pkg::*;

   localparam int POOL_SIZE    = 96;
   localparam int PHASE_ITEMS  = 90;
   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD    = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_SHOWN    = 10;

   typedef struct packed {
      logic                kind;
      logic [SLOT_W-1:0]   slot;
      logic                hit;
      logic                fill;
      logic                wb;
      logic [SECTOR_W-1:0] wb_sector;
      logic                last;
   } cache_answer_t;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [SECTOR_W-1:0] sector;
      bit                  typed;       // answer below replaces the predicted one
      bit                  has_answer;
      cache_answer_t       answer;
   } directed_row_t;

   localparam cache_answer_t NO_ANSWER = '0;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [SECTOR_W-1:0]    req_tdata   = '0;
   logic [OP_W-1:0]        req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_wr_en   = 1'b0;
   logic [PERIOD_W-1:0]    csr_wr_data = '0;

   // predicted cache state
   bit                     held_valid [NUM_SLOTS];
   bit                     held_dirty [NUM_SLOTS];
   logic [SECTOR_W-1:0]    held_sector[NUM_SLOTS];
   logic [STAMP_W-1:0]     held_stamp [NUM_SLOTS];
   logic [STAMP_W-1:0]     tick_count;
   logic [PERIOD_W-1:0]    flush_left;
   logic [PERIOD_W-1:0]    flush_period_q;

   cache_answer_t          cache_answers[$];
   logic [SECTOR_W-1:0]    sector_pool[POOL_SIZE];

   int                     send_idle_pct  = 0;
   int                     recv_stall_pct = 0;
   int                     hold_requests  = 0;
   int                     items_sent     = 0;
   int                     answers_seen   = 0;
   int                     hits_seen      = 0;
   int                     evict_wb_seen  = 0;
   int                     flush_wb_seen  = 0;
   int                     mismatches     = 0;

   directed_row_t dir_rows[22] = '{
      '{OP_READ,     32'h0000_0000, 1'b1, 1'b1,
        '{KIND_ACCESS, 6'd0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
      '{OP_WRITE,    32'hFFFF_FFFF, 1'b1, 1'b1,
        '{KIND_ACCESS, 6'd1, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
      // countdown starts at zero, so the first tick flushes slot 1
      '{OP_TICK,     32'hFFFF_FFFF, 1'b1, 1'b1,
        '{KIND_FLUSH,  6'd1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1}},
      '{OP_TICK,     32'h0000_0000, 1'b1, 1'b0, NO_ANSWER},
      '{OP_READ,     32'h0000_0000, 1'b1, 1'b1,
        '{KIND_ACCESS, 6'd0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
      '{OP_PREFETCH, 32'h5555_AAAA, 1'b1, 1'b1,
        '{KIND_ACCESS, 6'd2, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
      '{OP_WRITE,    32'h5555_AAAA, 1'b1, 1'b1,
        '{KIND_ACCESS, 6'd2, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
      '{OP_PREFETCH, 32'h0000_0000, 1'b1, 1'b1,
        '{KIND_ACCESS, 6'd0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
      '{OP_WRITE,    32'h1234_5678, 1'b0, 1'b0, NO_ANSWER},
      '{OP_READ,     32'h8000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_WRITE,    32'h0000_0001, 1'b0, 1'b0, NO_ANSWER},
      '{OP_PREFETCH, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_ANSWER},
      '{OP_WRITE,    32'hFFFF_FFFF, 1'b0, 1'b0, NO_ANSWER},
      // count down to the second flush with four dirty slots
      '{OP_TICK,     32'hAAAA_5555, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER},
      '{OP_TICK,     32'h0000_0000, 1'b0, 1'b0, NO_ANSWER}
   };

   lru_write_back_sector_cache_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // sector
      .req_tuser   (req_tuser),    // op
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      // slot, hit, fill_needed, writeback_needed, writeback_sector, zero fill
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),    // kind
      .rsp_tlast   (rsp_tlast),    // last
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)   // flush_period
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic string answer_text(input cache_answer_t a);
      return $sformatf("kind=%0d slot=%0d hit=%0d fill=%0d wb=%0d wb_sector=%h last=%0d",
                       a.kind, a.slot, a.hit, a.fill, a.wb, a.wb_sector, a.last);
   endfunction

   // tag match, free slot, lru victim and periodic flush for one accepted item
   task automatic lru_policy_step(input logic [OP_W-1:0] op,
                                  input logic [SECTOR_W-1:0] sector);
      int            hit_idx;
      int            free_idx;
      int            pick;
      int            flushed;
      cache_answer_t a;
      hit_idx  = -1;
      free_idx = -1;
      flushed  = 0;
      a        = '0;
      if (op == OP_TICK) begin
         tick_count = tick_count + 1'b1;
         if (flush_left <= 1) begin
            flush_left = flush_period_q;
            for (int i = 0; i < NUM_SLOTS && flushed < MAX_RESULTS; i++) begin
               if (held_valid[i] && held_dirty[i]) begin
                  a           = '0;
                  a.kind      = KIND_FLUSH;
                  a.slot      = SLOT_W'(i);
                  a.wb        = 1'b1;
                  a.wb_sector = held_sector[i];
                  cache_answers.push_back(a);
                  held_dirty[i] = 1'b0;
                  flushed++;
               end
            end
            if (flushed > 0) cache_answers[cache_answers.size() - 1].last = 1'b1;
         end else begin
            flush_left = flush_left - 1'b1;
         end
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit_idx < 0 && held_valid[i] && held_sector[i] == sector) hit_idx = i;
            if (free_idx < 0 && !held_valid[i]) free_idx = i;
         end
         a.kind = KIND_ACCESS;
         a.last = 1'b1;
         if (hit_idx >= 0) begin
            pick  = hit_idx;
            a.hit = 1'b1;
         end else begin
            a.fill = 1'b1;
            if (free_idx >= 0) begin
               pick = free_idx;
            end else begin
               // oldest stamp wins, lowest index on ties
               pick = 0;
               for (int i = 1; i < NUM_SLOTS; i++)
                  if (held_stamp[i] < held_stamp[pick]) pick = i;
               if (held_dirty[pick]) begin
                  a.wb        = 1'b1;
                  a.wb_sector = held_sector[pick];
               end
            end
            held_sector[pick] = sector;
            held_valid[pick]  = 1'b1;
            held_dirty[pick]  = 1'b0;
         end
         if (op != OP_PREFETCH) held_stamp[pick] = tick_count;
         if (op == OP_WRITE) held_dirty[pick] = 1'b1;
         a.slot = SLOT_W'(pick);
         cache_answers.push_back(a);
      end
   endtask

   task automatic offer_item(input logic [OP_W-1:0] op,
                             input logic [SECTOR_W-1:0] sector);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= sector;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_answers_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cache_answers.size() != 0) @(posedge clock);
   endtask

   task automatic set_flush_period(input logic [PERIOD_W-1:0] period);
      wait_answers_drained();
      // a tick with no result may still be walking the slots
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= period;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      flush_period_q = period;
   endtask

   // result side: check, then pick the ready level for the next edge
   initial begin : rsp_side
      int            hold_left;
      int            holds_served;
      cache_answer_t got;
      cache_answer_t want;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kind      = rsp_tuser;
            got.slot      = rsp_tdata[5:0];
            got.hit       = rsp_tdata[6];
            got.fill      = rsp_tdata[7];
            got.wb        = rsp_tdata[8];
            got.wb_sector = rsp_tdata[40:9];
            got.last      = rsp_tlast;
            answers_seen++;
            if (got.kind == KIND_FLUSH) flush_wb_seen++;
            else if (got.hit) hits_seen++;
            else if (got.wb) evict_wb_seen++;
            if (cache_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("%t: unexpected result item: %s", $realtime, answer_text(got));
            end else begin
               want = cache_answers.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN) begin
                     $display("%t: result %0d mismatch", $realtime, answers_seen);
                     $display("   expected %s", answer_text(want));
                     $display("   actual   %s", answer_text(got));
                  end
               end
            end
         end
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("%t: no item accepted for %0d cycles", $realtime, STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int                  r;
      int                  depth;
      logic [OP_W-1:0]     op;
      logic [SECTOR_W-1:0] sector;
      logic [PERIOD_W-1:0] mid_period;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         held_valid[i]  = 1'b0;
         held_dirty[i]  = 1'b0;
         held_sector[i] = '0;
         held_stamp[i]  = '0;
      end
      tick_count     = '0;
      flush_left     = '0;
      flush_period_q = PERIOD_RESET;
      for (int i = 0; i < POOL_SIZE; i++) sector_pool[i] = $urandom();
      mid_period = PERIOD_W'($urandom_range(40, 2));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         offer_item(dir_rows[i].op, dir_rows[i].sector);
         depth = cache_answers.size();
         lru_policy_step(dir_rows[i].op, dir_rows[i].sector);
         if (dir_rows[i].typed) begin
            while (cache_answers.size() > depth) void'(cache_answers.pop_back());
            if (dir_rows[i].has_answer) cache_answers.push_back(dir_rows[i].answer);
         end
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               set_flush_period(PERIOD_W'(3));
               send_idle_pct  = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               set_flush_period('0);    // behaves as one: every tick flushes
               send_idle_pct  = 62;
               recv_stall_pct <= 0;
            end
            2: begin
               set_flush_period(PERIOD_W'(1));
               send_idle_pct  = 0;
               recv_stall_pct <= 62;
            end
            3: begin
               set_flush_period(mid_period);
               send_idle_pct  = 17;
               recv_stall_pct <= 17;
            end
            default: begin
               set_flush_period({PERIOD_W{1'b1}});
               send_idle_pct  = 0;
               recv_stall_pct <= 0;
               // long output stall while items keep coming, so input backs up
               hold_requests <= hold_requests + 1;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == PHASE_ITEMS / 2) wait_answers_drained();
            r = $urandom_range(99);
            if (r < 20) op = OP_TICK;
            else if (r < 55) op = OP_READ;
            else if (r < 85) op = OP_WRITE;
            else op = OP_PREFETCH;
            if ($urandom_range(99) < 85) sector = sector_pool[$urandom_range(POOL_SIZE - 1)];
            else sector = $urandom();
            offer_item(op, sector);
            lru_policy_step(op, sector);
         end
      end

      wait_answers_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d items through flush periods 10, 3, 0, 1, %0d and 1023",
               items_sent, mid_period);
      $display("%0d result items: %0d hits, %0d dirty evictions, %0d flush writebacks, %0d mismatches",
               answers_seen, hits_seen, evict_wb_seen, flush_wb_seen, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
